// ===== rtl/core/dswt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dswt_pkg: shared definitions for the distinct source window tracker
// Table geometry, field widths, register indexes and the control and status
// structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package dswt_pkg;

    localparam int ENTRIES        = 3;
    localparam int ADDR_BITS      = 16;
    localparam int TIME_BITS      = 32;
    localparam int IDX_BITS       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int COUNT_BITS     = 5;
    localparam int THRESH_BITS    = 5;
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 32;

    localparam logic [TIME_BITS-1:0]   WINDOW_RESET = TIME_BITS'(3840);
    localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(3);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_WINDOW_TICKS    = 1'b0,
        REG_ALARM_THRESHOLD = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPDATE,
        S_COUNT
    } ctrl_state_t;

    typedef struct packed {
        logic load_item;
        logic update;
        logic load_result;
    } dp_cmd_t;

    typedef struct packed {
        logic in_null;
    } dp_status_t;

endpackage

// ===== rtl/core/dswt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dswt_ctrl: sequencing controller
// Accepts one word at a time, steps the datapath through table update and
// count, and owns the valid flag of the result register.
// ----------------------------------------------------------------------------
module dswt_ctrl
    import dswt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        in_ready        = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    // A null address leaves the table alone.
                    state_next = status.in_null ? S_COUNT : S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = S_COUNT;
            end
            S_COUNT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.load_result)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/core/dswt_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dswt_datapath: source table, configuration and result registers
// Holds the address and time table, matches and replaces entries, and
// counts the active entries for the result word.
// ----------------------------------------------------------------------------
module dswt_datapath
    import dswt_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic [ADDR_BITS-1:0]      source_address,
    input  logic [TIME_BITS-1:0]      current_time,
    input  dp_cmd_t                   cmd,
    output dp_status_t                status,
    output logic [COUNT_BITS-1:0]     active_count,
    output logic                      alarm
);

    logic [TIME_BITS-1:0]   window_reg;
    logic [THRESH_BITS-1:0] thresh_reg;

    logic [ADDR_BITS-1:0]   addr_reg;
    logic [TIME_BITS-1:0]   time_reg;

    logic [ADDR_BITS-1:0]   entry_addr_reg [ENTRIES];
    logic [TIME_BITS-1:0]   entry_time_reg [ENTRIES];

    logic [COUNT_BITS-1:0]  count_reg;
    logic                   alarm_reg;

    logic                   found;
    logic [IDX_BITS-1:0]    match_idx;
    logic [IDX_BITS-1:0]    victim_idx;
    logic [IDX_BITS-1:0]    write_idx;
    logic [COUNT_BITS-1:0]  count_next;
    logic                   alarm_next;
    logic [TIME_BITS-1:0]   age;

    assign status.in_null = (source_address == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_RESET;
            thresh_reg <= THRESH_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_WINDOW_TICKS:    window_reg <= cfg_data[TIME_BITS-1:0];
                REG_ALARM_THRESHOLD: thresh_reg <= cfg_data[THRESH_BITS-1:0];
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            addr_reg <= source_address;
            time_reg <= current_time;
        end
        if (cmd.load_result)
        begin
            count_reg <= count_next;
            alarm_reg <= alarm_next;
        end
    end

    // Match and oldest-entry search; the lowest index wins a tie.
    always_comb
    begin
        found      = 1'b0;
        match_idx  = '0;
        victim_idx = '0;
        for (int k = 0; k < ENTRIES; k++)
        begin
            if (!found && entry_addr_reg[k] == addr_reg)
            begin
                found     = 1'b1;
                match_idx = IDX_BITS'(k);
            end
            if (entry_time_reg[k] < entry_time_reg[victim_idx])
                victim_idx = IDX_BITS'(k);
        end
        write_idx = found ? match_idx : victim_idx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < ENTRIES; k++)
            begin
                entry_addr_reg[k] <= '0;
                entry_time_reg[k] <= '0;
            end
        end
        else if (cmd.update)
        begin
            for (int k = 0; k < ENTRIES; k++)
            begin
                if (write_idx == IDX_BITS'(k))
                begin
                    entry_time_reg[k] <= time_reg;
                    entry_addr_reg[k] <= addr_reg;
                end
            end
        end
    end

    always_comb
    begin
        count_next = '0;
        age        = '0;
        for (int k = 0; k < ENTRIES; k++)
        begin
            age = time_reg - entry_time_reg[k];
            if (entry_addr_reg[k] != '0 && age < window_reg)
                count_next = count_next + COUNT_BITS'(1);
        end
        alarm_next = (count_next >= thresh_reg);
    end

    assign active_count = count_reg;
    assign alarm        = alarm_reg;

endmodule

// ===== rtl/core/distinct_source_window_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distinct_source_window_tracker: active source counter over a time window
// Tracks recently seen source addresses and reports how many are active.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) carries one word per event: a
//   source address and the current tick count. Address zero only asks for
//   the count. The output channel (out_valid/out_ready) returns one word
//   per input word with active_count and alarm.
//   A word with a nonzero address passes through accept, table update and
//   count. A null word skips the update. The result is registered in the
//   count step, and a new word is accepted only once the controller has
//   left that step and is idle again.
//   in_ready is high only while the controller is idle.
//   The result sits in an output register; a stalled receiver holds it and
//   the next word may still be accepted and updated, waiting only in the
//   count step until the register is free.
//   Reset clears the table to null addresses and time zero, sets
//   window_ticks to 3840 and alarm_threshold to 3.
//   Configuration writes (cfg_write, cfg_index, cfg_data) take effect at
//   the clock edge and are to be issued while the block is idle.
// ----------------------------------------------------------------------------
module distinct_source_window_tracker
    import dswt_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [ADDR_BITS-1:0]      source_address,
    input  logic [TIME_BITS-1:0]      current_time,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [COUNT_BITS-1:0]     active_count,
    output logic                      alarm
);

    dp_cmd_t    cmd;
    dp_status_t status;

    dswt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    dswt_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .source_address (source_address),
        .current_time   (current_time),
        .cmd            (cmd),
        .status         (status),
        .active_count   (active_count),
        .alarm          (alarm)
    );

endmodule

// ===== rtl/core/dswt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dswt_checker: port-level checks for the tracker
// Watches the handshakes and result range at the top-level ports.
// ----------------------------------------------------------------------------
module dswt_checker
    import dswt_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [COUNT_BITS-1:0] active_count,
    input logic                  alarm
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(active_count) && $stable(alarm))
        else $error("result word changed while stalled");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> active_count <= COUNT_BITS'(ENTRIES))
        else $error("active count exceeds table size");

    // The controller works on one word at a time.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second word accepted while busy");

endmodule

bind distinct_source_window_tracker dswt_checker u_dswt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .active_count (active_count),
    .alarm        (alarm)
);

// ===== dv/dswt_tally_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dswt_tally_checker: tally predictor and comparator for the window tracker
// Watches the configuration port and both handshake channels. It keeps its
// own copy of the source table and registers, predicts active_count and
// alarm for every accepted event word, and compares each result word in
// order.
// ----------------------------------------------------------------------------
module dswt_tally_checker
    import dswt_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  logic [ADDR_BITS-1:0]      source_address,
    input  logic [TIME_BITS-1:0]      current_time,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  logic [COUNT_BITS-1:0]     active_count,
    input  logic                      alarm,
    output int                        mismatch_count,
    output int                        tallies_checked,
    output int                        tallies_pending
);

    typedef struct packed {
        logic [COUNT_BITS-1:0] count;
        logic                  alarm;
    } tally_t;

    logic [ADDR_BITS-1:0]   seen_addr [ENTRIES];
    logic [TIME_BITS-1:0]   seen_time [ENTRIES];
    logic [TIME_BITS-1:0]   window;
    logic [THRESH_BITS-1:0] threshold;
    tally_t                 expected_tallies [$];
    int                     fails;
    int                     checked;

    task automatic report_mismatch(input string what);
        fails++;
        $display("mismatch at %0t ns: %s", $time, what);
    endtask

    // Updates the source table with one event and returns the tally that
    // the block should report for it.
    function automatic tally_t tally_after_event(input logic [ADDR_BITS-1:0] addr,
                                                 input logic [TIME_BITS-1:0] now);
        int                   victim;
        bit                   found;
        int                   active;
        logic [TIME_BITS-1:0] age;
        tally_t               t;
        victim = 0;
        found  = 1'b0;
        active = 0;
        if (addr != '0)
        begin
            for (int k = 0; k < ENTRIES; k++)
            begin
                if (!found && seen_addr[k] == addr)
                begin
                    seen_time[k] = now;
                    found        = 1'b1;
                end
                // The oldest entry is picked by plain unsigned time, not by age.
                if (!found && seen_time[k] < seen_time[victim])
                    victim = k;
            end
            if (!found)
            begin
                seen_addr[victim] = addr;
                seen_time[victim] = now;
            end
        end
        for (int k = 0; k < ENTRIES; k++)
        begin
            age = now - seen_time[k];
            if (seen_addr[k] != '0 && age < window)
                active++;
        end
        t.count = COUNT_BITS'(active);
        t.alarm = (active >= int'(threshold));
        return t;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        tally_t want;
        if (!rst_n)
        begin
            for (int k = 0; k < ENTRIES; k++)
            begin
                seen_addr[k] = '0;
                seen_time[k] = '0;
            end
            window    = WINDOW_RESET;
            threshold = THRESH_RESET;
            expected_tallies.delete();
            fails     = 0;
            checked   = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_WINDOW_TICKS:    window    = cfg_data[TIME_BITS-1:0];
                    REG_ALARM_THRESHOLD: threshold = cfg_data[THRESH_BITS-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                expected_tallies.push_back(tally_after_event(source_address, current_time));
            if (out_valid && out_ready)
            begin
                if (expected_tallies.size() == 0)
                    report_mismatch($sformatf("result word count=%0d alarm=%0b with none expected",
                                              active_count, alarm));
                else
                begin
                    want = expected_tallies.pop_front();
                    checked++;
                    if (active_count !== want.count)
                        report_mismatch($sformatf("active_count %0d, expected %0d",
                                                  active_count, want.count));
                    if (alarm !== want.alarm)
                        report_mismatch($sformatf("alarm %0b, expected %0b (count %0d)",
                                                  alarm, want.alarm, want.count));
                end
            end
        end
        mismatch_count  <= fails;
        tallies_checked <= checked;
        tallies_pending <= expected_tallies.size();
    end

endmodule

// ===== dv/tb_distinct_source_window_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_distinct_source_window_tracker: testbench for the window tracker
// Drives directed corner events and then phases of random event streams,
// each under its own window and threshold setting, with bursty input and
// a stalling receiver. A separate checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_distinct_source_window_tracker;
    import dswt_pkg::*;

    localparam int PHASE_ITEMS = 80;
    localparam int HOLD_CYCLES = 100;

    logic                      clk            = 1'b0;
    logic                      rst_n          = 1'b0;
    logic                      cfg_write      = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index      = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data       = '0;
    logic                      in_valid       = 1'b0;
    logic                      in_ready;
    logic [ADDR_BITS-1:0]      source_address = '0;
    logic [TIME_BITS-1:0]      current_time   = '0;
    logic                      out_valid;
    logic                      out_ready      = 1'b0;
    logic [COUNT_BITS-1:0]     active_count;
    logic                      alarm;

    int mismatch_count;
    int tallies_checked;
    int tallies_pending;

    logic [TIME_BITS-1:0] tick;
    logic [TIME_BITS-1:0] cur_window;
    logic [ADDR_BITS-1:0] addr_pool [5];
    int                   burst_left;
    bit                   no_gaps;
    bit                   hold_request;
    int                   events_sent;
    int                   settings_used;

    always #5 clk = ~clk;

    distinct_source_window_tracker dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .source_address (source_address),
        .current_time   (current_time),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .active_count   (active_count),
        .alarm          (alarm)
    );

    dswt_tally_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .source_address  (source_address),
        .current_time    (current_time),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .active_count    (active_count),
        .alarm           (alarm),
        .mismatch_count  (mismatch_count),
        .tallies_checked (tallies_checked),
        .tallies_pending (tallies_pending)
    );

    // Offers one event word and returns at the edge where it is taken.
    task automatic send_event(input logic [ADDR_BITS-1:0] addr,
                              input logic [TIME_BITS-1:0] now);
        source_address <= addr;
        current_time   <= now;
        in_valid       <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        events_sent++;
    endtask

    // Between bursts the sender drops valid for a random pause, unless no_gaps is set.
    task automatic pace();
        if (no_gaps)
            return;
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8))
                @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end
        else
            burst_left--;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tallies_pending != 0)
            @(posedge clk);
        repeat (3)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [TIME_BITS-1:0] window,
                             input logic [CFG_DATA_BITS-1:0] thresh_data);
        wait_idle();
        write_reg(REG_WINDOW_TICKS, window);
        write_reg(REG_ALARM_THRESHOLD, thresh_data);
        cur_window = window;
        settings_used++;
    endtask

    // Mostly a small pool of repeating sources with time moving forward at
    // a pace near the window, so entries get refreshed, evicted and aged out.
    task automatic random_event();
        int                   pick;
        logic [ADDR_BITS-1:0] addr;
        logic [TIME_BITS-1:0] span;
        pick = $urandom_range(0, 99);
        if (pick < 15)
            addr = '0;
        else if (pick < 80)
            addr = addr_pool[$urandom_range(0, 4)];
        else
            addr = ADDR_BITS'($urandom_range(0, 65535));
        span = (cur_window < 8) ? 3 : (cur_window >> 1);
        if ($urandom_range(0, 99) < 8)
            tick = $urandom;
        else
            tick = tick + $urandom_range(0, span);
        send_event(addr, tick);
        pace();
    endtask

    task automatic run_phase(input logic [TIME_BITS-1:0] window,
                             input logic [CFG_DATA_BITS-1:0] thresh_data,
                             input logic [TIME_BITS-1:0] start_tick);
        configure(window, thresh_data);
        addr_pool[0] = 16'hFFFF;
        addr_pool[1] = 16'h0001;
        for (int k = 2; k < 5; k++)
            addr_pool[k] = ADDR_BITS'($urandom_range(1, 65535));
        tick = start_tick;
        repeat (PHASE_ITEMS)
            random_event();
    endtask

    // Receiver: stretches of steady acceptance, random stalls and periodic
    // stalls, plus one long hold-off on request so the block backs up.
    initial
    begin
        int period;
        int n;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                // Drain what is left, then hold off once words are offered again.
                out_ready <= 1'b1;
                @(posedge clk);
                while (!in_valid)
                    @(posedge clk);
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
            end
            case ($urandom_range(0, 2))
                0:
                begin
                    out_ready <= 1'b1;
                    repeat ($urandom_range(5, 40))
                        @(posedge clk);
                end
                1:
                begin
                    repeat ($urandom_range(5, 40))
                    begin
                        out_ready <= 1'($urandom_range(0, 1));
                        @(posedge clk);
                    end
                end
                default:
                begin
                    period = $urandom_range(2, 5);
                    n      = $urandom_range(5, 40);
                    for (int c = 0; c < n; c++)
                    begin
                        out_ready <= (c % period) != 0;
                        @(posedge clk);
                    end
                end
            endcase
        end
    end

    initial
    begin
        #2ms;
        $display("timeout with %0d results outstanding", tallies_pending);
        $display("status: fail");
        $finish;
    end

    initial
    begin
        burst_left    = 4;
        no_gaps       = 1'b0;
        hold_request  = 1'b0;
        events_sent   = 0;
        settings_used = 1;
        cur_window    = WINDOW_RESET;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: empty table, extreme fields, wrap of time, a
        // refresh, an eviction of the oldest entry and aging out.
        send_event(16'h0000, 32'h0000_0000);
        send_event(16'hFFFF, 32'hFFFF_FFFF);
        send_event(16'h0001, 32'h0000_0000);
        send_event(16'h8000, 32'h0000_0005);
        send_event(16'h0001, 32'h0000_000A);
        send_event(16'h5555, 32'h0000_0014);
        send_event(16'hAAAA, 32'h0000_001E);
        send_event(16'h0000, 32'h0000_0F0A);
        send_event(16'h0000, 32'h8000_0000);

        // Zero window counts nothing; zero threshold always alarms.
        configure(32'h0000_0000, 32'h0000_0000);
        send_event(16'h0001, 32'h0000_0028);
        send_event(16'h0000, 32'h0000_0029);

        // Window of one and a threshold above the table size.
        configure(32'h0000_0001, 32'hFFFF_FFE4);
        send_event(16'h1234, 32'h0000_0032);
        send_event(16'h0000, 32'h0000_0032);
        send_event(16'h0000, 32'h0000_0033);

        // Widest window, threshold from all-ones data.
        configure(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_event(16'hFFFE, 32'h0000_0000);
        send_event(16'h0000, 32'hFFFF_FFFE);

        configure(32'h8000_0000, ENTRIES);
        send_event(16'h0002, 32'h7FFF_FFFF);
        send_event(16'h0003, 32'h8000_0000);
        send_event(16'h0000, 32'hFFFF_FFFF);

        run_phase(WINDOW_RESET, THRESH_RESET, 32'hFFFF_F000);
        run_phase(32'h0000_0000, 32'h0000_0000, $urandom);
        hold_request = 1'b1;
        no_gaps      = 1'b1;
        run_phase(32'h0000_0001, 32'h0000_0001, $urandom);
        no_gaps      = 1'b0;
        run_phase(32'hFFFF_FFFF, 32'h0000_0010, $urandom);
        no_gaps      = 1'b1;
        run_phase($urandom_range(2, 64), 32'h0000_0002, $urandom);
        no_gaps      = 1'b0;
        run_phase($urandom_range(100, 5000), 32'hFFFF_FFE1, $urandom);
        run_phase($urandom, $urandom, $urandom);
        run_phase(WINDOW_RESET, THRESH_RESET, 32'hFFFF_FF00);

        wait_idle();
        repeat (5)
            @(posedge clk);
        $display("covered %0d event words under %0d window/threshold settings",
                 events_sent, settings_used);
        $display("%0d result words compared, %0d mismatches",
                 tallies_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
